/* rtl/vscd_pkg.sv */
// Package for the voxel surface cell detector: widths, register codes and microcode.
`timescale 1ns / 1ps
package vscd_pkg;

    // Fixed field widths.
    localparam int COORD_W    = 5;
    localparam int EDGE_W     = 6;
    localparam int DENS_W     = 8;
    localparam int LEVEL_W    = 2;
    localparam int CELL_W     = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ISO_THRESHOLD = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [EDGE_W-1:0] EDGE_RESET = 6'd32;
    localparam logic [DENS_W-1:0] ISO_RESET  = 8'd127;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_EDGE  = 32;
    localparam int DEF_LOD_COUNT = 4;

    // Sequencer program counter.
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_IDLE  = 4'd0;
    localparam t_pc PC_NN    = 4'd1;
    localparam t_pc PC_XNN   = 4'd2;
    localparam t_pc PC_YZ    = 4'd3;
    localparam t_pc PC_WRITE = 4'd4;
    localparam t_pc PC_LOD   = 4'd5;
    localparam t_pc PC_READ  = 4'd6;
    localparam t_pc PC_NEXT  = 4'd7;
    localparam t_pc PC_FLUSH = 4'd8;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_NN,
        UOP_XNN,
        UOP_YZ,
        UOP_WRITE,
        UOP_LOD,
        UOP_READ,
        UOP_NEXT,
        UOP_FLUSH
    } t_uop;

    // Jump condition: the jump to the target is taken when it holds.
    typedef enum logic [2:0] {
        UC_NEVER,
        UC_ALWAYS,
        UC_NO_GO,
        UC_NOT_APPLY,
        UC_COR_MORE,
        UC_LOD_MORE
    } t_ucond;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_pc    target;
    } t_uword;

    // The control store.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:  w = '{op: UOP_IDLE,  cond: UC_NO_GO,     target: PC_IDLE};
            PC_NN:    w = '{op: UOP_NN,    cond: UC_NEVER,     target: PC_IDLE};
            PC_XNN:   w = '{op: UOP_XNN,   cond: UC_NEVER,     target: PC_IDLE};
            PC_YZ:    w = '{op: UOP_YZ,    cond: UC_NEVER,     target: PC_IDLE};
            PC_WRITE: w = '{op: UOP_WRITE, cond: UC_NEVER,     target: PC_IDLE};
            PC_LOD:   w = '{op: UOP_LOD,   cond: UC_NOT_APPLY, target: PC_NEXT};
            PC_READ:  w = '{op: UOP_READ,  cond: UC_COR_MORE,  target: PC_READ};
            PC_NEXT:  w = '{op: UOP_NEXT,  cond: UC_LOD_MORE,  target: PC_LOD};
            PC_FLUSH: w = '{op: UOP_FLUSH, cond: UC_ALWAYS,    target: PC_IDLE};
            default:  w = '{op: UOP_IDLE,  cond: UC_ALWAYS,    target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

/* rtl/voxel_surface_cell_detector.sv */
// Top level of the voxel surface cell detector: sequencer, datapath and density store.
`timescale 1ns / 1ps
// A voxel is taken when start is high and busy is low; it is written into the density
// store and then every detail level whose step divides all three coordinates (and is
// not larger than any of them) is checked by reading the eight corners of the cell that
// ends at the voxel. Each surface cell is reported for exactly one cycle on
// o_result_strobe, in ascending level order, and o_last_of_run marks the final one of
// the item; the receiver cannot hold results off, so it must take every strobe. An item
// occupies the block while the linear index is formed and the voxel written, then for
// each level a setup step, the eight corner reads if the level applies and a result
// step, and last a flush of the pending result. The eight corner reads of a level all
// go through the one port of the density store. A voxel outside the grid in use is
// dropped. Configuration writes are taken at any edge with i_cfg_we high and must only
// be made while the block is idle.
module voxel_surface_cell_detector
    import vscd_pkg::*;
#(
    parameter int MAX_EDGE  = DEF_MAX_EDGE,
    parameter int LOD_COUNT = DEF_LOD_COUNT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Voxel command.
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_W-1:0]    i_vox_x,
    input  logic [COORD_W-1:0]    i_vox_y,
    input  logic [COORD_W-1:0]    i_vox_z,
    input  logic [DENS_W-1:0]     i_density_value,
    // Surface cell results.
    output logic                  o_result_strobe,
    output logic [LEVEL_W-1:0]    o_detail_level,
    output logic [CELL_W-1:0]     o_cell_index,
    output logic                  o_last_of_run
);

    // Store geometry. The linear index is never above the store depth, but it is also
    // kept at least as wide as the reported cell index.
    localparam int DEPTH    = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int IDX_W    = (ADDR_W > CELL_W) ? ADDR_W : CELL_W;
    localparam int LOD_W    = (LOD_COUNT > 1) ? $clog2(LOD_COUNT) : 1;
    localparam int NN_W     = 2 * EDGE_W;
    localparam int DIAG_W   = NN_W + 1;
    localparam int XNN_W    = COORD_W + NN_W;
    localparam int YN_W     = COORD_W + EDGE_W;
    localparam int EDGE_MAX = (1 << EDGE_W) - 1;
    localparam int EDGE_CAP = (MAX_EDGE > EDGE_MAX) ? EDGE_MAX : MAX_EDGE;
    localparam logic [LOD_W-1:0] LOD_LAST = LOD_W'(LOD_COUNT - 1);

    // Configuration registers.
    logic [EDGE_W-1:0] r_edge_count;
    logic [DENS_W-1:0] r_iso_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count    <= EDGE_RESET;
            r_iso_threshold <= ISO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_EDGE_COUNT:    r_edge_count    <= i_cfg_data[EDGE_W-1:0];
                REG_ISO_THRESHOLD: r_iso_threshold <= i_cfg_data;
            endcase
        end
    end

    // Edge length in use: clamped to the range the store supports.
    logic [EDGE_W-1:0] w_n;

    always_comb begin
        if (r_edge_count < EDGE_W'(2)) begin
            w_n = EDGE_W'(2);
        end else if (int'(r_edge_count) > MAX_EDGE) begin
            w_n = EDGE_W'(EDGE_CAP);
        end else begin
            w_n = r_edge_count;
        end
    end

    // Sequencer state.
    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;

    // Datapath registers.
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COORD_W-1:0] r_z;
    logic [DENS_W-1:0]  r_dens;
    logic [NN_W-1:0]    r_nn;
    logic [DIAG_W-1:0]  r_diag;
    logic [IDX_W-1:0]   r_acc;
    logic [IDX_W-1:0]   r_low;
    logic [IDX_W-1:0]   r_snn;
    logic [IDX_W-1:0]   r_sn;
    logic [IDX_W-1:0]   r_s;
    logic [LOD_W-1:0]   r_lod;
    logic [2:0]         r_cor;
    logic [3:0]         r_cnt;
    logic               r_rd_vld;

    // The pending result waits until it is known whether a later level also reports.
    logic               r_pend_vld;
    logic [LOD_W-1:0]   r_pend_lod;
    logic [CELL_W-1:0]  r_pend_idx;

    // Output registers.
    logic               r_out_vld;
    logic [LEVEL_W-1:0] r_out_lod;
    logic [CELL_W-1:0]  r_out_idx;
    logic               r_out_last;

    logic w_accept;
    logic w_in_grid;
    logic w_go;

    assign busy      = (r_pc != PC_IDLE);
    assign w_accept  = start && !busy;
    assign w_in_grid = ({1'b0, i_vox_x} < w_n) && ({1'b0, i_vox_y} < w_n) &&
                       ({1'b0, i_vox_z} < w_n);
    assign w_go      = w_accept && w_in_grid;

    // Level check: the step divides every coordinate and none is below the step.
    logic [7:0] w_step;
    logic [7:0] w_mask;
    logic [7:0] w_x8;
    logic [7:0] w_y8;
    logic [7:0] w_z8;
    logic       w_apply;

    assign w_step  = 8'd1 << r_lod;
    assign w_mask  = w_step - 8'd1;
    assign w_x8    = 8'(r_x);
    assign w_y8    = 8'(r_y);
    assign w_z8    = 8'(r_z);
    assign w_apply = (w_x8 >= w_step) && (w_y8 >= w_step) && (w_z8 >= w_step) &&
                     ((w_x8 & w_mask) == 8'd0) && ((w_y8 & w_mask) == 8'd0) &&
                     ((w_z8 & w_mask) == 8'd0);

    // Next program counter.
    always_comb begin
        logic take;
        w_uw = ucode(r_pc);
        unique case (w_uw.cond)
            UC_NEVER:     take = 1'b0;
            UC_ALWAYS:    take = 1'b1;
            UC_NO_GO:     take = !w_go;
            UC_NOT_APPLY: take = !w_apply;
            UC_COR_MORE:  take = (r_cor != 3'd7);
            UC_LOD_MORE:  take = (r_lod != LOD_LAST);
            default:      take = 1'b1;
        endcase
        n_pc = take ? w_uw.target : t_pc'(r_pc + t_pc'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Store access.
    logic [DENS_W-1:0] w_rdata;
    logic [IDX_W-1:0]  w_cor_addr;
    logic [ADDR_W-1:0] w_addr;
    logic              w_we;
    logic              w_above;
    logic [3:0]        w_cnt_fin;
    logic              w_hit;

    assign w_cor_addr = r_low + (r_cor[0] ? r_snn : '0) + (r_cor[1] ? r_sn : '0) +
                        (r_cor[2] ? r_s : '0);
    assign w_we       = (w_uw.op == UOP_WRITE);
    assign w_addr     = w_we ? r_acc[ADDR_W-1:0] : w_cor_addr[ADDR_W-1:0];

    vscd_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (r_dens),
        .o_rdata (w_rdata)
    );

    // A corner read returns in the cycle after it is issued.
    assign w_above   = r_rd_vld && (w_rdata > r_iso_threshold);
    assign w_cnt_fin = r_cnt + 4'(w_above);
    assign w_hit     = r_rd_vld && (w_cnt_fin != 4'd0) && (w_cnt_fin != 4'd8);

    // Datapath payload registers.
    always_ff @(posedge i_clk) begin
        case (w_uw.op)
            UOP_IDLE: begin
                if (w_accept) begin
                    r_x    <= i_vox_x;
                    r_y    <= i_vox_y;
                    r_z    <= i_vox_z;
                    r_dens <= i_density_value;
                end
            end
            UOP_NN: begin
                r_nn <= NN_W'(w_n) * NN_W'(w_n);
            end
            UOP_XNN: begin
                r_acc <= IDX_W'(XNN_W'(r_x) * XNN_W'(r_nn));
            end
            UOP_YZ: begin
                r_acc  <= r_acc + IDX_W'(YN_W'(r_y) * YN_W'(w_n)) + IDX_W'(r_z);
                r_diag <= DIAG_W'(r_nn) + DIAG_W'(w_n) + DIAG_W'(1);
            end
            UOP_LOD: begin
                r_low <= r_acc - (IDX_W'(r_diag) << r_lod);
                r_snn <= IDX_W'(r_nn) << r_lod;
                r_sn  <= IDX_W'(w_n) << r_lod;
                r_s   <= IDX_W'(1) << r_lod;
            end
            default: begin
            end
        endcase
    end

    // Level loop control, tally and result hand-off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lod      <= '0;
            r_cor      <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            r_rd_vld   <= (w_uw.op == UOP_READ);
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
            case (w_uw.op)
                UOP_WRITE: begin
                    r_lod <= '0;
                end
                UOP_LOD: begin
                    r_cor <= '0;
                    r_cnt <= '0;
                end
                UOP_READ: begin
                    r_cor <= r_cor + 3'd1;
                    r_cnt <= w_cnt_fin;
                end
                UOP_NEXT: begin
                    if (w_hit) begin
                        // A new surface cell: the one still pending is not the last.
                        r_out_vld  <= r_pend_vld;
                        r_out_lod  <= LEVEL_W'(8'(r_pend_lod));
                        r_out_idx  <= r_pend_idx;
                        r_pend_vld <= 1'b1;
                        r_pend_lod <= r_lod;
                        r_pend_idx <= r_low[CELL_W-1:0];
                    end
                    if (r_lod != LOD_LAST) begin
                        r_lod <= r_lod + LOD_W'(1);
                    end
                end
                UOP_FLUSH: begin
                    r_out_vld  <= r_pend_vld;
                    r_out_last <= r_pend_vld;
                    r_out_lod  <= LEVEL_W'(8'(r_pend_lod));
                    r_out_idx  <= r_pend_idx;
                    r_pend_vld <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_result_strobe = r_out_vld;
    assign o_detail_level  = r_out_lod;
    assign o_cell_index    = r_out_idx;
    assign o_last_of_run   = r_out_last;

endmodule

/* rtl/vscd_store.sv */
// Single-port density store with a registered read port.
`timescale 1ns / 1ps
module vscd_store
    import vscd_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_EDGE * DEF_MAX_EDGE * DEF_MAX_EDGE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DENS_W-1:0] i_wdata,
    output logic [DENS_W-1:0] o_rdata
);

    logic [DENS_W-1:0] r_mem [DEPTH];
    logic [DENS_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/vscd_checker.sv */
// Port-level checker for the voxel surface cell detector, with its bind.
`timescale 1ns / 1ps
module vscd_checker
    import vscd_pkg::*;
#(
    parameter int LOD_COUNT = DEF_LOD_COUNT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_result_strobe,
    input logic [LEVEL_W-1:0] o_detail_level,
    input logic               o_last_of_run
);

    // No result can be ready in the cycle right after a voxel is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_result_strobe)
        else $error("result strobe right after a voxel was accepted");

    // A result that is not the last leaves the block still working on the item.
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_last_of_run) |-> busy)
        else $error("run ended without a last result");

    // The last result closes the run: nothing follows in the next cycle.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_last_of_run) |=> !o_result_strobe)
        else $error("result strobe after the last result of a run");

    // Reported levels stay within the configured number of levels.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (int'(o_detail_level) < LOD_COUNT))
        else $error("detail level out of range");

endmodule

bind voxel_surface_cell_detector vscd_checker #(
    .LOD_COUNT (LOD_COUNT)
) u_vscd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_result_strobe (o_result_strobe),
    .o_detail_level  (o_detail_level),
    .o_last_of_run   (o_last_of_run)
);
